// ----- hw/rtl/cti_pkg.sv -----
// ---------------------------------------------------------------------------
// cti_pkg: shared widths and types for the circle/triangle intersection test
// Coordinate width and the widths derived from it, and per-edge flags.
// ---------------------------------------------------------------------------
package cti_pkg;

   localparam int COORD_BITS = 12;
   localparam int RAD_BITS   = COORD_BITS - 1;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int RSQ_BITS   = 2 * RAD_BITS;
   localparam int MAG_BITS   = 2 * COORD_BITS + 1;
   localparam int WIDE_BITS  = 2 * MAG_BITS;
   localparam int EDGE_LAT   = 6;

   typedef struct packed {
      logic vertex_hit;
      logic cross_neg;
      logic edge_hit;
   } edge_flags_type;

endpackage

// ----- hw/rtl/cti_edge.sv -----
// ---------------------------------------------------------------------------
// cti_edge: one vertex/edge slice of the intersection test
// Vertex-in-circle, winding sign and edge-distance tests for edge a->b,
// six register stages, free running.
// ---------------------------------------------------------------------------
module cti_edge (
   input  logic                                clock,
   input  logic signed [cti_pkg::COORD_BITS-1:0] px,
   input  logic signed [cti_pkg::COORD_BITS-1:0] py,
   input  logic signed [cti_pkg::COORD_BITS-1:0] ax,
   input  logic signed [cti_pkg::COORD_BITS-1:0] ay,
   input  logic signed [cti_pkg::COORD_BITS-1:0] bx,
   input  logic signed [cti_pkg::COORD_BITS-1:0] by,
   input  logic        [cti_pkg::RAD_BITS-1:0]   radius,
   output cti_pkg::edge_flags_type             flags
);

   localparam int D = cti_pkg::DIFF_BITS;
   localparam int P = cti_pkg::PROD_BITS;
   localparam int S = cti_pkg::SUM_BITS;
   localparam int R = cti_pkg::RSQ_BITS;
   localparam int U = cti_pkg::MAG_BITS;
   localparam int W = cti_pkg::WIDE_BITS;

   // stage A: differences
   logic signed [D-1:0] cx_ff, cy_ff, ex_ff, ey_ff;
   logic [cti_pkg::RAD_BITS-1:0] r_ff;
   // stage B: products
   logic signed [P-1:0] cxx_ff, cyy_ff, kx_ff, ky_ff, cr1_ff, cr2_ff, exx_ff, eyy_ff;
   logic [R-1:0] rsq_b_ff;
   // stage C: sums
   logic signed [S-1:0] dsq_ff, k_ff, len_ff, cross_ff;
   logic [R-1:0] rsq_c_ff;
   // stage D: compares
   logic vhit_d_ff, cneg_d_ff, ok_d_ff, tle_d_ff;
   logic [U-1:0] km_ff, lm_ff, tm_ff;
   logic signed [S-1:0] t_in;
   // stage E: wide products
   logic vhit_e_ff, cneg_e_ff, ok_e_ff, tle_e_ff;
   logic [W-1:0] kk_ff, tl_ff;
   // stage F: result
   cti_pkg::edge_flags_type flags_ff, flags_in;

   assign t_in = dsq_ff - $signed({{(S-R){1'b0}}, rsq_c_ff});

   always_comb begin
      flags_in.vertex_hit = vhit_e_ff;
      flags_in.cross_neg  = cneg_e_ff;
      flags_in.edge_hit   = ok_e_ff && (tle_e_ff || (kk_ff >= tl_ff));
   end

   always_ff @(posedge clock) begin
      cx_ff  <= D'(px) - D'(ax);
      cy_ff  <= D'(py) - D'(ay);
      ex_ff  <= D'(bx) - D'(ax);
      ey_ff  <= D'(by) - D'(ay);
      r_ff   <= radius;

      cxx_ff   <= P'(cx_ff) * P'(cx_ff);
      cyy_ff   <= P'(cy_ff) * P'(cy_ff);
      kx_ff    <= P'(cx_ff) * P'(ex_ff);
      ky_ff    <= P'(cy_ff) * P'(ey_ff);
      cr1_ff   <= P'(ey_ff) * P'(cx_ff);
      cr2_ff   <= P'(ex_ff) * P'(cy_ff);
      exx_ff   <= P'(ex_ff) * P'(ex_ff);
      eyy_ff   <= P'(ey_ff) * P'(ey_ff);
      rsq_b_ff <= R'(r_ff) * R'(r_ff);

      dsq_ff   <= S'(cxx_ff) + S'(cyy_ff);
      k_ff     <= S'(kx_ff) + S'(ky_ff);
      len_ff   <= S'(exx_ff) + S'(eyy_ff);
      cross_ff <= S'(cr1_ff) - S'(cr2_ff);
      rsq_c_ff <= rsq_b_ff;

      vhit_d_ff <= dsq_ff <= $signed({{(S-R){1'b0}}, rsq_c_ff});
      cneg_d_ff <= cross_ff < 0;
      ok_d_ff   <= (k_ff > 0) && (k_ff < len_ff);
      tle_d_ff  <= t_in <= 0;
      km_ff     <= k_ff[U-1:0];
      lm_ff     <= len_ff[U-1:0];
      tm_ff     <= t_in[U-1:0];

      // floor(k*k/len) >= t  <=>  k*k >= t*len for t > 0
      vhit_e_ff <= vhit_d_ff;
      cneg_e_ff <= cneg_d_ff;
      ok_e_ff   <= ok_d_ff;
      tle_e_ff  <= tle_d_ff;
      kk_ff     <= W'(km_ff) * W'(km_ff);
      tl_ff     <= W'(tm_ff) * W'(lm_ff);

      flags_ff <= flags_in;
   end

   assign flags = flags_ff;

endmodule

// ----- hw/rtl/circle_triangle_intersection.sv -----
// ---------------------------------------------------------------------------
// circle_triangle_intersection: circle versus triangle overlap test
// Pipelined test of one circle against one triangle per beat.
// ---------------------------------------------------------------------------
// Usage:
//   Drive a circle (req_center_x/y, req_radius) and a triangle
//   (req_vertex0..2_x/y) and raise start; the beat is taken on any edge
//   with start high, and busy is always low, so a new beat may follow
//   every cycle.
//   Each beat yields one result: rsp_valid is high for one cycle with
//   rsp_intersects set when the shapes touch or overlap.
//   Throughput is one beat per cycle. A beat passes the input registers,
//   the per-edge stages and the result register. The per-edge depth is set
//   by the arithmetic: differences, products, sums, compares, the wide
//   products that replace the division, and the final compare, each
//   registered. Results leave in issue order. The receiver cannot stall,
//   so no beat is ever held back.
//   Reset (synchronous) clears all valid bits; items in flight are dropped.
// ---------------------------------------------------------------------------
module circle_triangle_intersection (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [cti_pkg::COORD_BITS-1:0] req_center_x,
   input  logic signed [cti_pkg::COORD_BITS-1:0] req_center_y,
   input  logic        [cti_pkg::RAD_BITS-1:0]   req_radius,
   input  logic signed [cti_pkg::COORD_BITS-1:0] req_vertex0_x,
   input  logic signed [cti_pkg::COORD_BITS-1:0] req_vertex0_y,
   input  logic signed [cti_pkg::COORD_BITS-1:0] req_vertex1_x,
   input  logic signed [cti_pkg::COORD_BITS-1:0] req_vertex1_y,
   input  logic signed [cti_pkg::COORD_BITS-1:0] req_vertex2_x,
   input  logic signed [cti_pkg::COORD_BITS-1:0] req_vertex2_y,
   output logic                                rsp_valid,
   output logic                                rsp_intersects
);

   localparam int N = cti_pkg::COORD_BITS;
   localparam int L = cti_pkg::EDGE_LAT;

   logic in_vld_ff;
   logic signed [N-1:0] px_ff, py_ff, v0x_ff, v0y_ff, v1x_ff, v1y_ff, v2x_ff, v2y_ff;
   logic [cti_pkg::RAD_BITS-1:0] r_ff;
   logic [L-1:0] vld_ff, vld_in;
   cti_pkg::edge_flags_type e0, e1, e2;
   logic rsp_valid_ff, rsp_hit_ff, hit_in;

   assign busy   = 1'b0;
   assign vld_in = {vld_ff[L-2:0], in_vld_ff};
   assign hit_in = e0.vertex_hit | e1.vertex_hit | e2.vertex_hit
                 | ~(e0.cross_neg | e1.cross_neg | e2.cross_neg)
                 | e0.edge_hit | e1.edge_hit | e2.edge_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_vld_ff    <= start;
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[L-1];
      end
      px_ff      <= req_center_x;
      py_ff      <= req_center_y;
      r_ff       <= req_radius;
      v0x_ff     <= req_vertex0_x;
      v0y_ff     <= req_vertex0_y;
      v1x_ff     <= req_vertex1_x;
      v1y_ff     <= req_vertex1_y;
      v2x_ff     <= req_vertex2_x;
      v2y_ff     <= req_vertex2_y;
      rsp_hit_ff <= hit_in;
   end

   cti_edge u_edge0 (
      .clock(clock), .px(px_ff), .py(py_ff),
      .ax(v0x_ff), .ay(v0y_ff), .bx(v1x_ff), .by(v1y_ff),
      .radius(r_ff), .flags(e0)
   );

   cti_edge u_edge1 (
      .clock(clock), .px(px_ff), .py(py_ff),
      .ax(v1x_ff), .ay(v1y_ff), .bx(v2x_ff), .by(v2y_ff),
      .radius(r_ff), .flags(e1)
   );

   cti_edge u_edge2 (
      .clock(clock), .px(px_ff), .py(py_ff),
      .ax(v2x_ff), .ay(v2y_ff), .bx(v0x_ff), .by(v0y_ff),
      .radius(r_ff), .flags(e2)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_intersects = rsp_hit_ff;

endmodule

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench: circle/triangle intersection test bench
// Sends circle/triangle beats with bursty gaps, predicts each answer with an
// exact integer model and compares every rsp_valid beat against it in order.
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  DRAIN_CYCLES = 40;
   localparam longint CYCLE_LIMIT = 200000;

   typedef logic signed [cti_pkg::COORD_BITS-1:0] coord_type;
   typedef logic [cti_pkg::RAD_BITS-1:0] rad_type;
   typedef struct {
      coord_type px, py;
      rad_type rad;
      coord_type vx[3], vy[3];
   } query_type;

   logic clock = 0, reset = 1, start = 0;
   logic busy, rsp_valid, rsp_intersects;
   coord_type cx_in = 0, cy_in = 0, v0x = 0, v0y = 0, v1x = 0, v1y = 0, v2x = 0, v2y = 0;
   rad_type rad_in = 0;

   logic expected_hits[$];
   int mismatches = 0;
   longint cycles = 0;
   int burst_left = 0;

   always #2 clock = ~clock;

   circle_triangle_intersection dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_center_x(cx_in), .req_center_y(cy_in), .req_radius(rad_in),
      .req_vertex0_x(v0x), .req_vertex0_y(v0y), .req_vertex1_x(v1x),
      .req_vertex1_y(v1y), .req_vertex2_x(v2x), .req_vertex2_y(v2y),
      .rsp_valid(rsp_valid), .rsp_intersects(rsp_intersects)
   );

   function automatic logic predict_intersects(query_type q);
      longint px, py, rsq, cx, cy, ex, ey, dsq, k, len, quo;
      longint vx[3], vy[3];
      logic hit, in_tri;
      int j;
      px = q.px; py = q.py; rsq = longint'(q.rad) * longint'(q.rad);
      hit = 1'b0; in_tri = 1'b1;
      for (int i = 0; i < 3; i++) begin
         vx[i] = q.vx[i]; vy[i] = q.vy[i];
      end
      for (int i = 0; i < 3; i++) begin
         j = (i == 2) ? 0 : i + 1;
         cx = px - vx[i]; cy = py - vy[i];
         ex = vx[j] - vx[i]; ey = vy[j] - vy[i];
         dsq = cx * cx + cy * cy;
         if (dsq <= rsq) hit = 1'b1;
         if (ey * cx - ex * cy < 0) in_tri = 1'b0;
         k = cx * ex + cy * ey;
         len = ex * ex + ey * ey;
         if (k > 0 && len > 0 && k < len) begin
            quo = (k * k) / len;
            if (dsq - quo <= rsq) hit = 1'b1;
         end
      end
      return hit | in_tri;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (expected_hits.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected beat: got %0b", rsp_intersects);
         end else begin
            logic e;
            e = expected_hits.pop_front();
            if (e !== rsp_intersects) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("intersects mismatch: expected %0b got %0b", e, rsp_intersects);
            end
         end
      end
   end

   task automatic send_query(query_type q);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            start <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      end
      burst_left--;
      start <= 1;
      cx_in <= q.px; cy_in <= q.py; rad_in <= q.rad;
      v0x <= q.vx[0]; v0y <= q.vy[0]; v1x <= q.vx[1];
      v1y <= q.vy[1]; v2x <= q.vx[2]; v2y <= q.vy[2];
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_hits.push_back(predict_intersects(q));
   endtask

   task automatic idle_until_drained();
      start <= 0;
      @(posedge clock);
      while (expected_hits.size() != 0) @(posedge clock);
   endtask

   function automatic query_type make_query(int px, int py, int r, int ax, int ay,
                                            int bx, int by, int qx, int qy);
      query_type q;
      q.px = coord_type'(px); q.py = coord_type'(py); q.rad = rad_type'(r);
      q.vx[0] = coord_type'(ax); q.vy[0] = coord_type'(ay);
      q.vx[1] = coord_type'(bx); q.vy[1] = coord_type'(by);
      q.vx[2] = coord_type'(qx); q.vy[2] = coord_type'(qy);
      return q;
   endfunction

   function automatic coord_type rand_coord();
      return coord_type'($urandom);
   endfunction

   function automatic coord_type near(coord_type c, int spread);
      return coord_type'(int'(c) + $urandom_range(0, 2 * spread) - spread);
   endfunction

   task automatic test_directed();
      send_query(make_query(0, 0, 0, 0, 0, 100, 0, 0, 100));
      send_query(make_query(5, 5, 0, 0, 0, 100, 0, 0, 100));
      send_query(make_query(5, 5, 0, 0, 0, 0, 100, 100, 0));
      send_query(make_query(50, -10, 10, 0, 0, 100, 0, 0, 100));
      send_query(make_query(50, -11, 10, 0, 0, 100, 0, 0, 100));
      send_query(make_query(10, 10, 3, 0, 0, 0, 0, 0, 0));
      send_query(make_query(10, 10, 3, 0, 0, 0, 0, 50, 50));
      send_query(make_query(-2048, -2048, 2047, 2047, 2047, 2047, -2048, -2048, 2047));
      send_query(make_query(2047, 2047, 0, -2048, -2048, -2048, 2047, 2047, -2048));
      send_query(make_query(-2048, 2047, 2047, 2047, -2048, 2047, -2048, 2047, -2048));
      send_query(make_query(0, 0, 2047, -2048, -2048, 2047, -2048, 0, 2047));
      send_query(make_query(-1, -1, 1, -2048, 2047, 2047, 2047, 0, -2048));
      send_query(make_query(0, 0, 1, 1, 1, 3, 1, 1, 3));
      send_query(make_query(7, 0, 3, 0, 4, 10, 4, 0, 4));
      idle_until_drained();
   endtask

   task automatic test_random(int count);
      query_type q;
      int shape;
      for (int n = 0; n < count; n++) begin
         shape = $urandom_range(0, 3);
         q.px = rand_coord(); q.py = rand_coord(); q.rad = rad_type'($urandom);
         for (int i = 0; i < 3; i++) begin
            q.vx[i] = rand_coord(); q.vy[i] = rand_coord();
         end
         if (shape != 0) begin
            if (shape == 1) q.rad = rad_type'($urandom_range(0, 300));
            else q.rad = rad_type'($urandom_range(0, 40));
            for (int i = 0; i < 3; i++) begin
               q.vx[i] = near(q.px, shape == 3 ? 30 : 400);
               q.vy[i] = near(q.py, shape == 3 ? 30 : 400);
            end
         end
         send_query(q);
         if (n == count / 2) idle_until_drained();
      end
      idle_until_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random(1750);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_hits.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
